// ===== design/mec_pkg.sv =====
// Package for the mesh Euler characteristic block: edge job type and hash helpers.
// Used by mec_front, mec_fifo, mec_back and mesh_euler_characteristic.
package mec_pkg;

  localparam int unsigned PidW = 14;
  localparam int unsigned KeyW = 28;
  localparam int unsigned DefMaxPoints = 16384;
  localparam int unsigned DefEdgeSlots = 65536;
  localparam logic [31:0] HashMul = 32'd2654435761;

  localparam logic [1:0] KindRing = 2'd0;
  localparam logic [1:0] KindStrip = 2'd1;

  // One word from front to back: at most a pair of edge keys, a mesh-end mark and the domain.
  typedef struct packed {
    logic            e0_valid;
    logic [KeyW-1:0] e0_key;
    logic            e1_valid;
    logic [KeyW-1:0] e1_key;
    logic            last;
    logic [15:0]     dom;
  } mec_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HASH,
    BK_READ,
    BK_CHECK,
    BK_FINISH,
    BK_CLEAR
  } bk_state_t;

  function automatic logic [KeyW-1:0] edge_key(input logic [PidW-1:0] a,
                                               input logic [PidW-1:0] b);
    logic [PidW-1:0] lo;
    logic [PidW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return {lo, hi};
  endfunction

endpackage

// ===== design/mec_front.sv =====
// Front part: accepts vertex words, tracks the current cell, marks used points
// and produces edge jobs. Depends on mec_pkg.
module mec_front #(
  parameter int unsigned MAX_POINTS = mec_pkg::DefMaxPoints
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mec_pkg::PidW-1:0]    point_id,
  input  logic [1:0]                  cell_kind,
  input  logic                        cell_end,
  input  logic                        mesh_end,
  input  logic [15:0]                 domain_id,
  output logic                        job_valid,
  input  logic                        job_stall,
  output mec_pkg::mec_job_t           job,
  output logic [14:0]                 vert_count,
  output logic [15:0]                 cell_count,
  input  logic                        counts_clear
);
  import mec_pkg::*;

  localparam int unsigned MapW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned ClrW = MapW + 1;

  // Point map is a memory; a clearing pass runs after reset and each mesh end.
  logic map_mem [MAX_POINTS];
  logic [ClrW-1:0] clr_idx;
  logic clearing;
  logic mesh_wait;

  // Stage 1: registered vertex with its map read result, waiting for its map update.
  logic s1_valid;
  logic [PidW-1:0] s1_pid;
  logic s1_inrange;
  logic s1_rd;

  logic [PidW-1:0] first_point, previous_point, second_previous_point;
  logic [1:0] seen;

  logic accept;
  logic cnt_clr;

  assign in_stall = clearing || mesh_wait || s1_valid || (job_valid && job_stall);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (clearing) begin
      map_mem[clr_idx[MapW-1:0]] <= 1'b0;
    end else if (s1_valid && s1_inrange && !s1_rd) begin
      map_mem[s1_pid[MapW-1:0]] <= 1'b1;
    end
    if (accept) begin
      s1_rd <= map_mem[point_id[MapW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      mesh_wait <= 1'b0;
      s1_valid <= 1'b0;
      job_valid <= 1'b0;
      vert_count <= '0;
      cell_count <= '0;
      seen <= '0;
      first_point <= '0;
      previous_point <= '0;
      second_previous_point <= '0;
    end else begin
      if (clearing) begin
        if (clr_idx == ClrW'(MAX_POINTS - 1)) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + 1'b1;
      end
      if (counts_clear) begin
        mesh_wait <= 1'b0;
        clearing <= 1'b1;
        clr_idx <= '0;
        vert_count <= '0;
        cell_count <= '0;
      end
      if (job_valid && !job_stall) begin
        job_valid <= 1'b0;
      end
      if (s1_valid) begin
        s1_valid <= 1'b0;
        if (s1_inrange && !s1_rd) begin
          vert_count <= vert_count + 1'b1;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
        s1_pid <= point_id;
        s1_inrange <= ({18'd0, point_id} < 32'(MAX_POINTS));
        job_valid <= 1'b1;
        job.dom <= domain_id;
        job.last <= mesh_end;
        job.e0_valid <= ((cell_kind == KindRing) || (cell_kind == KindStrip))
                        && (seen != 2'd0);
        job.e0_key <= edge_key(previous_point, point_id);
        job.e1_valid <= ((cell_kind == KindRing) && (cell_end || mesh_end)
                         && (seen != 2'd0))
                        || ((cell_kind == KindStrip) && (seen >= 2'd2));
        job.e1_key <= (cell_kind == KindRing) ? edge_key(point_id, first_point)
                                              : edge_key(second_previous_point, point_id);
        if (seen == 2'd0) begin
          first_point <= point_id;
        end
        second_previous_point <= previous_point;
        previous_point <= point_id;
        if (cell_end || mesh_end) begin
          seen <= '0;
          if (cell_count != 16'hFFFF) begin
            cell_count <= cell_count + 1'b1;
          end
        end else if (seen != 2'd3) begin
          seen <= seen + 1'b1;
        end
        if (mesh_end) begin
          mesh_wait <= 1'b1;
          first_point <= '0;
          previous_point <= '0;
          second_previous_point <= '0;
        end
      end
    end
  end

  assign cnt_clr = counts_clear;

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept) else $error("accept during map clear");
  a_cell_sat: assert property (@(posedge clk) disable iff (rst)
    ($past(cell_count) == 16'hFFFF && !$past(cnt_clr)) |-> cell_count == 16'hFFFF)
    else $error("cell counter wrapped");
  a_one_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> !s1_valid) else $error("map stage held two cycles");
`endif
endmodule

// ===== design/mec_fifo.sv =====
// Short queue of edge jobs between front and back parts. Depends on mec_pkg.
module mec_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  mec_pkg::mec_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_stall,
  output mec_pkg::mec_job_t rd_data
);
  import mec_pkg::*;

  mec_job_t slots [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic wr, rd;

  assign wr_stall = (cnt == 3'd4);
  assign rd_valid = (cnt != 3'd0);
  assign rd_data = slots[rp];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + {2'b0, wr} - {2'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 3'd1) else $error("queue count slip");
  a_cnt_drop: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> cnt == $past(cnt) - 3'd1) else $error("queue count slip");
`endif
endmodule

// ===== design/mec_back.sv =====
// Back part: inserts edges into the hashed table with linear probing, counts
// distinct edges, emits the result and sweeps the table at mesh end. Depends on mec_pkg.
module mec_back #(
  parameter int unsigned EDGE_SLOTS = mec_pkg::DefEdgeSlots
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_stall,
  input  mec_pkg::mec_job_t job,
  input  logic [14:0]       vert_count,
  input  logic [15:0]       cell_count,
  output logic              counts_clear,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       domain_tag,
  output logic signed [17:0] euler_number,
  output logic [14:0]       used_vertices,
  output logic [16:0]       distinct_edges,
  output logic [15:0]       face_total,
  output logic              table_overflow
);
  import mec_pkg::*;

  localparam int unsigned SlotW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int unsigned CntW = SlotW + 1;
  localparam int unsigned EntW = KeyW + 1;

  logic [EntW-1:0] table_mem [EDGE_SLOTS];
  logic [EntW-1:0] rd_entry;

  bk_state_t state, state_next;
  logic which;                 // low picks e0_key, high picks e1_key
  logic [KeyW-1:0] key;
  logic [SlotW-1:0] prod;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] rd_addr;
  logic [CntW-1:0] probes;
  logic [CntW-1:0] clr_idx;
  logic [16:0] edge_count;
  logic overflow_flag;
  mec_job_t cur;

  logic do_write, do_clear;
  logic entry_hit, entry_free, wrap_probe;
  logic [KeyW-1:0] key_sel;

  assign entry_hit = (rd_entry == {1'b1, key});
  assign entry_free = !rd_entry[KeyW];
  assign wrap_probe = (probes == CntW'(EDGE_SLOTS - 1));
  assign key_sel = (which) ? cur.e1_key : cur.e0_key;
  // The first probe reads the home slot straight from the hash.
  assign rd_addr = (state == BK_READ && probes == '0) ? prod : slot;

  always_ff @(posedge clk) begin
    if (do_clear) begin
      table_mem[clr_idx[SlotW-1:0]] <= '0;
    end else if (do_write) begin
      table_mem[slot] <= {1'b1, key};
    end
    rd_entry <= table_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    job_stall = 1'b1;
    do_write = 1'b0;
    do_clear = 1'b0;
    counts_clear = 1'b0;
    case (state)
      BK_IDLE: begin
        job_stall = 1'b0;
        if (job_valid) begin
          if (job.e0_valid || job.e1_valid) state_next = BK_HASH;
          else if (job.last) state_next = BK_FINISH;
        end
      end
      BK_HASH: state_next = BK_READ;
      BK_READ: state_next = BK_CHECK;
      BK_CHECK: begin
        if (!entry_hit && entry_free) do_write = 1'b1;
        if (entry_hit || entry_free || wrap_probe) begin
          if (!which && cur.e1_valid) state_next = BK_HASH;
          else if (cur.last) state_next = BK_FINISH;
          else state_next = BK_IDLE;
        end else begin
          state_next = BK_READ;
        end
      end
      BK_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = BK_CLEAR;
          counts_clear = 1'b1;
        end
      end
      BK_CLEAR: begin
        do_clear = 1'b1;
        if (clr_idx == CntW'(EDGE_SLOTS - 1)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr_idx <= '0;
      edge_count <= '0;
      overflow_flag <= 1'b0;
      out_valid <= 1'b0;
      which <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (job_valid) begin
            cur <= job;
            which <= !job.e0_valid;
          end
        end
        BK_HASH: begin
          key <= key_sel;
          prod <= SlotW'(key_sel) * SlotW'(HashMul);
        end
        BK_READ: begin
          if (probes == '0) slot <= prod;
        end
        BK_CHECK: begin
          if (!entry_hit && entry_free) edge_count <= edge_count + 1'b1;
          else if (!entry_hit && wrap_probe) overflow_flag <= 1'b1;
          if (!(entry_hit || entry_free || wrap_probe)) begin
            slot <= slot + 1'b1;
          end else begin
            which <= 1'b1;
          end
        end
        BK_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            domain_tag <= cur.dom;
            euler_number <= 18'({3'd0, vert_count}) - 18'({1'b0, edge_count})
                            + 18'({2'd0, cell_count});
            used_vertices <= vert_count;
            distinct_edges <= edge_count;
            face_total <= cell_count;
            table_overflow <= overflow_flag;
            clr_idx <= '0;
          end
        end
        BK_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          edge_count <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Probe counter: reset on a new hash, advanced on each miss.
  always_ff @(posedge clk) begin
    if (state == BK_HASH) probes <= '0;
    else if (state == BK_CHECK && !(entry_hit || entry_free || wrap_probe))
      probes <= probes + 1'b1;
  end

`ifndef SYNTHESIS
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    do_write |-> !rd_entry[KeyW]) else $error("write over a used slot");
  a_no_job_clear: assert property (@(posedge clk) disable iff (rst)
    state == BK_CLEAR |-> job_stall) else $error("job taken during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(euler_number))
    else $error("result changed under stall");
`endif
endmodule

// ===== design/mesh_euler_characteristic.sv =====
// Top level of the mesh Euler characteristic block.
// Depends on mec_pkg, mec_front, mec_fifo and mec_back.
//
// Usage: one input word per cell vertex arrives on the in channel (in_valid,
// in_stall) with point_id, cell_kind, cell_end, mesh_end and domain_id. When the
// word carrying mesh_end has been worked off, one result word leaves on the out
// channel (out_valid, out_stall): vertices minus edges plus cells, with the counts.
// The front part takes no new word while the last one is still in its map stage;
// it updates the point map and forms at most a pair of edge keys, and a four-entry queue
// passes them to the back part. The back part takes a word in its idle state,
// then hashes each key (one multiply) and probes the edge table slot by slot,
// a read state and a check state per probe, until a hit, a free slot or a full
// wrap; the rate at which words are taken is set by the slower of the two parts.
// After reset, and after each result, the point map and the edge table are swept
// clear, entry by entry. No input is taken during the
// point map sweep; words taken while the edge table is still being swept wait in
// the queue, and input stalls once the queue is full.
// A stalled result holds its value; the back part waits for the result register
// to drain before finishing the next mesh, and the front stalls after that mesh's last word.
module mesh_euler_characteristic #(
  parameter int unsigned MAX_POINTS = mec_pkg::DefMaxPoints,
  parameter int unsigned EDGE_SLOTS = mec_pkg::DefEdgeSlots
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [13:0]              point_id,
  input  logic [1:0]               cell_kind,
  input  logic                     cell_end,
  input  logic                     mesh_end,
  input  logic [15:0]              domain_id,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              domain_tag,
  output logic signed [17:0]       euler_number,
  output logic [14:0]              used_vertices,
  output logic [16:0]              distinct_edges,
  output logic [15:0]              face_total,
  output logic                     table_overflow
);
  import mec_pkg::*;

  mec_job_t fj, bj;
  logic fj_valid, fj_stall, bj_valid, bj_stall;
  logic [14:0] vert_count;
  logic [15:0] cell_count;
  logic counts_clear;

  mec_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .point_id, .cell_kind, .cell_end,
    .mesh_end, .domain_id, .job_valid(fj_valid), .job_stall(fj_stall),
    .job(fj), .vert_count, .cell_count, .counts_clear
  );

  mec_fifo u_fifo (
    .clk, .rst, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
    .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data(bj)
  );

  mec_back #(.EDGE_SLOTS(EDGE_SLOTS)) u_back (
    .clk, .rst, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj),
    .vert_count, .cell_count, .counts_clear, .out_valid, .out_stall,
    .domain_tag, .euler_number, .used_vertices, .distinct_edges,
    .face_total, .table_overflow
  );

`ifndef SYNTHESIS
  a_euler_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> euler_number == 18'({3'd0, used_vertices})
      - 18'({1'b0, distinct_edges}) + 18'({2'd0, face_total}))
    else $error("euler sum mismatch");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    counts_clear |-> in_stall) else $error("input taken while finishing mesh");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(domain_tag))
    else $error("result moved under stall");
`endif
endmodule
